// ===== hw/rtl/rfrt_pkg.sv =====
// Shared types and codes of the retransmit tracker.
package rfrt_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int ACT_W     = 4;

    localparam logic [7:0] ACK_PAYLOAD_BYTES = 8'd4;

    // Event codes of an input item.
    localparam logic [1:0] MODE_TRACK = 2'd0;
    localparam logic [1:0] MODE_ACK   = 2'd1;
    localparam logic [1:0] MODE_SWEEP = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_TRACK = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_RETX  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_REQ  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TYPE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NACK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATT  = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] now_ms;
        logic [7:0]  frame_type;
        logic [7:0]  frame_flags;
        logic [15:0] frame_sequence;
        logic [7:0]  frame_handle;
        logic [7:0]  pay_len;
        logic [7:0]  ack_tgt_type;
        logic [15:0] ack_tgt_seq;
        logic        tx_ready;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic             ok;
        logic [7:0]       out_handle;
        logic [7:0]       out_type;
        logic [15:0]      out_sequence;
        logic [3:0]       out_attempts;
        logic [15:0]      retries_total;
        logic [ACT_W-1:0] active_entries;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [15:0]          wdata;
    } t_cfg_item;

    typedef struct packed {
        logic [7:0]  ack_required_code;
        logic [7:0]  ack_type_code;
        logic [7:0]  nack_type_code;
        logic [15:0] retry_interval_ms;
        logic [3:0]  max_attempts;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  etype;
        logic [15:0] seq_num;
        logic [7:0]  handle;
        logic [3:0]  attempts;
        logic [31:0] sent_time;
    } t_entry;

endpackage

// ===== hw/rtl/rfrt_if.sv =====
// Handshake channels of the retransmit tracker.
interface rfrt_in_if;
    import rfrt_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface rfrt_out_if;
    import rfrt_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface rfrt_cfg_if;
    import rfrt_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/rfrt_cfg_regs.sv =====
// Configuration register file of the retransmit tracker.
module rfrt_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rfrt_cfg_if.sink      i_cfg,
    output rfrt_pkg::t_cfg o_cfg
);
    import rfrt_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_required_code <= 8'd1;
            r_cfg.ack_type_code     <= 8'd1;
            r_cfg.nack_type_code    <= 8'd2;
            r_cfg.retry_interval_ms <= 16'd500;
            r_cfg.max_attempts      <= 4'd3;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                CFG_ACK_REQ:  r_cfg.ack_required_code <= i_cfg.data.wdata[7:0];
                CFG_ACK_TYPE: r_cfg.ack_type_code     <= i_cfg.data.wdata[7:0];
                CFG_NACK:     r_cfg.nack_type_code    <= i_cfg.data.wdata[7:0];
                CFG_INTERVAL: r_cfg.retry_interval_ms <= i_cfg.data.wdata;
                CFG_MAX_ATT:  r_cfg.max_attempts      <= i_cfg.data.wdata[3:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/rfrt_engine.sv =====
// Table sequencer: entry memory, valid bits, scan FSM and result register.
module rfrt_engine #(
    parameter int ENTRIES = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rfrt_pkg::t_cfg i_cfg,
    rfrt_in_if.sink        i_item,
    rfrt_out_if.source     o_result
);
    import rfrt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {S_IDLE, S_TRACK, S_SCAN, S_EVAL, S_FIN} t_state;

    t_state             r_state, n_state;
    t_in_item           r_req, n_req;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]   r_active, n_active;
    logic [15:0]        r_retry, n_retry;
    logic               r_ok, n_ok;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    t_entry             r_mem [ENTRIES];
    t_entry             r_rdata;

    logic               mem_we, mem_re;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    t_entry             mem_wdata;

    logic               out_free;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   cur;
    logic               due, hit, ack_frame;
    logic [CNT_W-1:0]   idx_inc;

    assign i_item.ready   = (r_state == S_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    assign out_free  = !r_out_valid || o_result.ready;
    assign cur       = r_idx[IDX_W-1:0];
    assign idx_inc   = r_idx + CNT_W'(1);
    assign due       = (r_req.now_ms - r_rdata.sent_time) >= {16'd0, i_cfg.retry_interval_ms};
    assign hit       = (r_rdata.etype == r_req.ack_tgt_type) &&
                       (r_rdata.seq_num == r_req.ack_tgt_seq);
    assign ack_frame = ((i_item.data.frame_type == i_cfg.ack_type_code) ||
                        (i_item.data.frame_type == i_cfg.nack_type_code)) &&
                       (i_item.data.pay_len == ACK_PAYLOAD_BYTES);

    // Lowest free slot.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_idx       = r_idx;
        n_valid     = r_valid;
        n_active    = r_active;
        n_retry     = r_retry;
        n_ok        = r_ok;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_result.ready;
        mem_we      = 1'b0;
        mem_waddr   = cur;
        mem_wdata   = r_rdata;
        mem_re      = 1'b0;
        mem_raddr   = cur;

        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_req = i_item.data;
                    n_idx = '0;
                    n_ok  = 1'b0;
                    case (i_item.data.mode)
                        MODE_TRACK: n_state = S_TRACK;
                        MODE_ACK:   n_state = ack_frame ? S_SCAN : S_FIN;
                        MODE_SWEEP: n_state = S_SCAN;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end

            S_TRACK: begin
                n_ok    = 1'b1;
                n_state = S_FIN;
                if (r_req.frame_flags == i_cfg.ack_required_code) begin
                    n_ok = free_found;
                    if (free_found) begin
                        mem_we              = 1'b1;
                        mem_waddr           = free_idx;
                        mem_wdata.etype     = r_req.frame_type;
                        mem_wdata.seq_num   = r_req.frame_sequence;
                        mem_wdata.handle    = r_req.frame_handle;
                        mem_wdata.attempts  = 4'd1;
                        mem_wdata.sent_time = r_req.now_ms;
                        n_valid[free_idx]   = 1'b1;
                        n_active            = r_active + CNT_W'(1);
                    end
                end
            end

            S_SCAN: begin
                if (r_idx == CNT_W'(ENTRIES)) begin
                    n_state = S_FIN;
                end else if (r_valid[cur]) begin
                    mem_re  = 1'b1;
                    n_state = S_EVAL;
                end else begin
                    n_idx = idx_inc;
                end
            end

            S_EVAL: begin
                if (r_req.mode == MODE_ACK) begin
                    if (hit) begin
                        n_valid[cur] = 1'b0;
                        n_active     = r_active - CNT_W'(1);
                        n_ok         = 1'b1;
                        n_state      = S_FIN;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = S_SCAN;
                    end
                end else if (!due) begin
                    n_idx   = idx_inc;
                    n_state = S_SCAN;
                end else if (r_rdata.attempts >= i_cfg.max_attempts) begin
                    n_valid[cur] = 1'b0;
                    n_active     = r_active - CNT_W'(1);
                    n_idx        = idx_inc;
                    n_state      = S_SCAN;
                end else if (!r_req.tx_ready) begin
                    n_idx   = idx_inc;
                    n_state = S_SCAN;
                end else if (out_free) begin
                    // Resend: write back the bumped attempt count and new send time.
                    mem_we              = 1'b1;
                    mem_wdata.attempts  = r_rdata.attempts + 4'd1;
                    mem_wdata.sent_time = r_req.now_ms;
                    n_retry             = r_retry + 16'd1;
                    n_out               = '0;
                    n_out.kind          = KIND_RETX;
                    n_out.out_handle    = r_rdata.handle;
                    n_out.out_type      = r_rdata.etype;
                    n_out.out_sequence  = r_rdata.seq_num;
                    n_out.out_attempts  = r_rdata.attempts + 4'd1;
                    n_out.retries_total = r_retry + 16'd1;
                    n_out.active_entries = ACT_W'(r_active);
                    n_out_valid         = 1'b1;
                    n_idx               = idx_inc;
                    n_state             = S_SCAN;
                end
            end

            S_FIN: begin
                if (out_free) begin
                    n_out = '0;
                    case (r_req.mode)
                        MODE_TRACK: n_out.kind = KIND_TRACK;
                        MODE_ACK:   n_out.kind = KIND_ACK;
                        default:    n_out.kind = KIND_END;
                    endcase
                    n_out.ok             = r_ok;
                    n_out.retries_total  = r_retry;
                    n_out.active_entries = ACT_W'(r_active);
                    n_out.last           = 1'b1;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req       <= '0;
            r_idx       <= '0;
            r_valid     <= '0;
            r_active    <= '0;
            r_retry     <= '0;
            r_ok        <= 1'b0;
            r_out       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_req       <= n_req;
            r_idx       <= n_idx;
            r_valid     <= n_valid;
            r_active    <= n_active;
            r_retry     <= n_retry;
            r_ok        <= n_ok;
            r_out       <= n_out;
            r_out_valid <= n_out_valid;
        end
    end

    // Entry memory. Writes and reads fall in different states, so the same
    // entry is never written and read in one cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active == CNT_W'($countones(r_valid)))
        else $error("active count disagrees with valid bits");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("entry memory written and read in one cycle");

    a_track_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRACK && mem_we) |-> !r_valid[mem_waddr])
        else $error("track overwrote an occupied entry");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= CNT_W'(ENTRIES))
        else $error("scan index ran past the table");

endmodule

// ===== hw/rtl/reliable_frame_retransmit_tracker.sv =====
// Top level of the acknowledgement retransmit tracker.
//
//  Channel    Dir  Payload       Accepted when
//  i_cfg      in   t_cfg_item    i_cfg.valid && i_cfg.ready (ready is always high)
//  i_item     in   t_in_item     i_item.valid && i_item.ready
//  o_result   out  t_out_item    o_result.valid && o_result.ready
//
// One item is worked at a time over the entry memory's single read port. A
// track passes S_TRACK then S_FIN. An ack or a sweep scans the slots from 0,
// reading each occupied one in S_EVAL, and goes to S_FIN past the last slot or
// at an ack's match. A malformed ack goes straight to S_FIN; mode 3 has no result.
// A stalled result register holds the scan in place until it drains.
// Synchronous reset clears the valid bits at once; no clearing pass is needed.
module reliable_frame_retransmit_tracker #(
    parameter int ENTRIES = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    rfrt_cfg_if.sink   i_cfg,
    rfrt_in_if.sink    i_item,
    rfrt_out_if.source o_result
);
    import rfrt_pkg::*;

    t_cfg cfg_regs;

    rfrt_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg_regs)
    );

    rfrt_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_regs),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule
